@@ sv/bfra_pkg.sv @@
package bfra_pkg;

    localparam int REGION_ENTRIES = 32;
    localparam int ADDRESS_BITS   = 16;
    localparam int LEN_W          = 17;
    localparam int IDX_W          = $clog2(REGION_ENTRIES);
    localparam int POOL_RESET     = 65536;

    typedef enum logic [2:0] {
        ST_REUSED     = 3'd0,
        ST_NEW        = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_FREED      = 3'd4,
        ST_NOT_FOUND  = 3'd5
    } t_status;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [LEN_W-1:0]        req_size;
        logic [ADDRESS_BITS-1:0] req_address;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [ADDRESS_BITS-1:0] region_address;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } t_dstat;

endpackage

@@ sv/bfra_ctrl.sv @@
module bfra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  bfra_pkg::t_dstat i_stat,
    output bfra_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import bfra_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SCAN;
                        r_busy  <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (i_stat.last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.read   = (r_state == S_SCAN);
        o_cmd.finish = (r_state == S_FINISH);
    end

    assign o_busy = r_busy;

endmodule

@@ sv/bfra_dpath.sv @@
module bfra_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bfra_pkg::t_cmd             i_cmd,
    input  bfra_pkg::t_req             i_req,
    input  logic [bfra_pkg::LEN_W-1:0] i_pool_size,
    output bfra_pkg::t_dstat           o_stat,
    output logic                       o_result_valid,
    output bfra_pkg::t_result          o_result
);
    import bfra_pkg::*;

    localparam int ENTRY_W = ADDRESS_BITS + LEN_W;

    // Region table: start and length in a memory, valid and in-use flags in flops.
    logic [ENTRY_W-1:0]        mem [REGION_ENTRIES];
    logic [REGION_ENTRIES-1:0] r_valid;
    logic [REGION_ENTRIES-1:0] r_in_use;
    logic [LEN_W-1:0]          r_break;

    // Latched request.
    logic                    r_type;
    logic [LEN_W-1:0]        r_size;
    logic [ADDRESS_BITS-1:0] r_addr;

    // Scan pipeline.
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_cmp_vld;
    logic [ENTRY_W-1:0] r_rd;

    // Scan results.
    logic                    r_best_found;
    logic [IDX_W-1:0]        r_best_idx;
    logic [LEN_W-1:0]        r_best_len;
    logic [ADDRESS_BITS-1:0] r_best_start;
    logic                    r_slot_found;
    logic [IDX_W-1:0]        r_slot_idx;

    t_result r_result;
    logic    r_result_valid;

    logic [ADDRESS_BITS-1:0] rd_start;
    logic [LEN_W-1:0]        rd_len;
    logic                    cmp_v;
    logic                    cmp_u;
    logic                    take_best;
    logic                    take_slot;
    logic [LEN_W:0]          end_sum;
    logic                    no_space;
    t_status                 n_status;
    logic [ADDRESS_BITS-1:0] n_region;
    logic                    do_new;

    assign rd_start = r_rd[ENTRY_W-1:LEN_W];
    assign rd_len   = r_rd[LEN_W-1:0];
    assign cmp_v    = r_valid[r_cmp_idx];
    assign cmp_u    = r_in_use[r_cmp_idx];

    always_comb begin
        take_best = 1'b0;
        take_slot = 1'b0;
        if (r_cmp_vld) begin
            if (r_type == REQ_ALLOC) begin
                take_slot = !cmp_v && !r_slot_found;
                take_best = cmp_v && !cmp_u && (rd_len >= r_size) &&
                            (!r_best_found || (rd_len < r_best_len));
            end else begin
                take_best = cmp_v && cmp_u && (rd_start == r_addr) && !r_best_found;
            end
        end
    end

    assign end_sum  = {1'b0, r_break} + {1'b0, r_size};
    assign no_space = (end_sum > {1'b0, i_pool_size}) || ((r_break >> ADDRESS_BITS) != '0);

    always_comb begin
        n_region = '0;
        do_new   = 1'b0;
        if (r_type == REQ_ALLOC) begin
            if (r_best_found) begin
                n_status = ST_REUSED;
                n_region = r_best_start;
            end else if (no_space) begin
                n_status = ST_NO_SPACE;
            end else if (!r_slot_found) begin
                n_status = ST_TABLE_FULL;
            end else begin
                n_status = ST_NEW;
                n_region = ADDRESS_BITS'(r_break);
                do_new   = 1'b1;
            end
        end else begin
            n_status = r_best_found ? ST_FREED : ST_NOT_FOUND;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= '0;
            r_in_use       <= '0;
            r_break        <= '0;
            r_cmp_vld      <= 1'b0;
            r_best_found   <= 1'b0;
            r_slot_found   <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_cmp_vld      <= i_cmd.read;
            r_result_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_best_found <= 1'b0;
                r_slot_found <= 1'b0;
            end else begin
                if (take_best) begin
                    r_best_found <= 1'b1;
                end
                if (take_slot) begin
                    r_slot_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                if (r_type == REQ_ALLOC) begin
                    if (r_best_found) begin
                        r_in_use[r_best_idx] <= 1'b1;
                    end else if (do_new) begin
                        r_valid[r_slot_idx]  <= 1'b1;
                        r_in_use[r_slot_idx] <= 1'b1;
                        r_break              <= end_sum[LEN_W-1:0];
                    end
                end else if (r_best_found) begin
                    r_in_use[r_best_idx] <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req.req_type;
            r_size <= i_req.req_size;
            r_addr <= i_req.req_address;
            r_idx  <= '0;
        end else if (i_cmd.read) begin
            r_idx <= r_idx + 1'b1;
        end
        r_cmp_idx <= r_idx;
        if (take_best) begin
            r_best_idx   <= r_cmp_idx;
            r_best_len   <= rd_len;
            r_best_start <= rd_start;
        end
        if (take_slot) begin
            r_slot_idx <= r_cmp_idx;
        end
        if (i_cmd.finish) begin
            r_result.status         <= n_status;
            r_result.region_address <= n_region;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && do_new) begin
            mem[r_slot_idx] <= {ADDRESS_BITS'(r_break), r_size};
        end
        if (i_cmd.read) begin
            r_rd <= mem[r_idx];
        end
    end

    assign o_stat.last    = (r_idx == IDX_W'(REGION_ENTRIES - 1));
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

@@ sv/best_fit_region_allocator.sv @@
// Best-fit region allocator. Assert start with a request on i_req while busy
// is low; the item is taken at that clock edge and busy rises. Every request
// scans the whole region table, one entry per cycle through the table memory's
// registered read port, followed by a compare-drain step and an update step.
// The result is shown on o_result for exactly one cycle, flagged by
// o_result_valid; the receiver cannot stall it and must capture it then.
// Busy is low in that cycle, so a new request may be issued in that same
// cycle; no new request is taken before the last result is shown. The
// pool size register is written through the APB port at byte address 0 and
// should only be changed while the block is idle. No clearing pass is needed
// after reset: the table's valid and in-use flags are flops cleared by reset.
module best_fit_region_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bfra_pkg::t_req             i_req,
    output logic                       o_result_valid,
    output bfra_pkg::t_result          o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bfra_pkg::*;

    t_cmd             cmd;
    t_dstat           dstat;
    logic [LEN_W-1:0] r_pool_size;
    logic             cfg_write;
    logic             unused_paddr;

    // The only register sits at address 0; every byte address of the port
    // maps onto it.
    assign cfg_write    = psel && penable && pwrite && pready;
    assign unused_paddr = ^paddr;
    assign pready       = 1'b1;
    assign prdata       = {{(32 - LEN_W){1'b0}}, r_pool_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= LEN_W'(POOL_RESET);
        end else if (cfg_write) begin
            r_pool_size <= pwdata[LEN_W-1:0];
        end
    end

    // The controller sequences the scan; the datapath holds the table,
    // the break pointer and the best-fit search registers.
    bfra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !unused_paddr | start),
        .i_stat  (dstat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bfra_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req          (i_req),
        .i_pool_size    (r_pool_size),
        .o_stat         (dstat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // An accepted request always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted request");

    // A result is only presented once the scan has finished.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result presented while still busy");

    // Each request produces a single one-cycle result.
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // Only allocations that succeed return a region address.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result.status != ST_REUSED) && (o_result.status != ST_NEW)
        |-> (o_result.region_address == '0))
        else $error("nonzero address with a failing or free status");

endmodule
